>>> rtl/mfd_pkg.sv
// Shared types and constants for the MFM flux decoder.
`default_nettype none
package mfd_pkg;

  localparam int MaxCellsDef = 64;
  localparam int MaxResults  = 6;

  localparam logic [15:0] SYNC_MARK  = 16'h4489;
  localparam logic [4:0]  WORD_CELLS = 5'd16;
  localparam logic [4:0]  CC_WRAP    = 5'd19;
  localparam logic [4:0]  CC_BACK    = 5'd18;

  localparam logic [2:0] LVL_UNSYNC = 3'd0;
  localparam logic [2:0] LVL_SYNC1  = 3'd1;
  localparam logic [2:0] LVL_SYNC3  = 3'd3;
  localparam logic [2:0] LVL_DATA   = 3'd4;

  localparam int          CFG_IDX_W    = 2;
  localparam logic [1:0]  REG_BIT_TIME = 2'd0;
  localparam logic [1:0]  REG_MAX_GAP  = 2'd1;

  localparam logic [15:0] BIT_TIME_RST = 16'd336;
  localparam logic [31:0] MAX_GAP_RST  = 32'd2000;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch interval, update last timestamp
    logic drop;        // interval too long: go unsync
    logic count_step;  // subtract one cell, count one empty cell
    logic set_flag;    // empty-cell run clamped
    logic shift;       // shift one cell
    logic shift_bit;
    logic put_status;  // closing status result
  } mfd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic gap_over;
    logic d_gt_thr;
    logic cnt_full;
    logic cnt_zero;
    logic out_busy;
  } mfd_stat_t;

endpackage
`default_nettype wire

>>> rtl/mfm_flux_decoder_unit.sv
// Top level of the MFM flux decoder with 0x4489 sync detection.
`default_nettype none
// Each input transfer carries the timer value of one flux transition. The
// decoder turns the interval since the previous transition into a run of
// empty cells and one set cell, shifts them one cell per clock while the
// result side does not stall, and returns zero or more byte results followed
// by one status result (last = 1). The run holds Z empty cells, at most
// MAX_CELLS: the run-length counter subtracts one cell length per clock,
// then the shifter takes the cells; an interval above max_gap skips both and
// goes straight to the status result. Configuration writes are taken at any
// time but must only be issued
// while the decoder is idle.
module mfm_flux_decoder_unit #(
  parameter int MAX_CELLS = mfd_pkg::MaxCellsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   capture_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    data_byte,
  output logic                          byte_valid,
  output logic [2:0]                    sync_state,
  output logic                          gap_clamped,
  output logic                          last
);
  import mfd_pkg::*;

  mfd_cmd_t  cmd;
  mfd_stat_t stat;

  mfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfd_datapath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .capture_time (capture_time),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .sync_state   (sync_state),
    .gap_clamped  (gap_clamped),
    .last         (last)
  );

endmodule
`default_nettype wire

>>> rtl/mfd_ctrl.sv
// Sequencer for the MFM flux decoder: interval check, run count, cell shifting.
`default_nettype none
module mfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfd_pkg::mfd_stat_t stat,
  output mfd_pkg::mfd_cmd_t  cmd
);
  import mfd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_COUNT,
    S_SHIFT,
    S_STATUS
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load = accept;
      S_GAP:   cmd.drop = stat.gap_over;
      S_COUNT: begin
        if (stat.d_gt_thr) begin
          if (stat.cnt_full) cmd.set_flag = 1'b1;
          else cmd.count_step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift     = !stat.out_busy;
        cmd.shift_bit = stat.cnt_zero;
      end
      S_STATUS: cmd.put_status = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_GAP;
            in_stall <= 1'b1;
          end
        end
        S_GAP: state <= stat.gap_over ? S_STATUS : S_COUNT;
        S_COUNT: begin
          if (!stat.d_gt_thr || stat.cnt_full) state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (!stat.out_busy && stat.cnt_zero) state <= S_STATUS;
        end
        S_STATUS: begin
          if (!stat.out_busy) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/mfd_datapath.sv
// Datapath: config registers, interval counter, MFM shifters, sync logic, result register.
`default_nettype none
module mfd_datapath #(
  parameter int MAX_CELLS = mfd_pkg::MaxCellsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic [31:0]                    capture_time,
  input  mfd_pkg::mfd_cmd_t              cmd,
  output mfd_pkg::mfd_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     data_byte,
  output logic                           byte_valid,
  output logic [2:0]                     sync_state,
  output logic                           gap_clamped,
  output logic                           last
);
  import mfd_pkg::*;

  localparam int CNT_W = $clog2(MAX_CELLS + 1);
  localparam int BC_W  = $clog2(MaxResults);

  logic [15:0] bit_time;
  logic [31:0] max_gap;

  logic [31:0] last_time;
  logic [15:0] raw_window;
  logic [7:0]  data_shift;
  logic [4:0]  cell_count;
  logic [2:0]  sync_level;

  logic [31:0]      interval;
  logic [CNT_W-1:0] zero_cnt;
  logic             flag;
  logic [BC_W-1:0]  byte_cnt;

  logic [14:0] cell_len;
  logic [15:0] thr;

  logic [15:0] raw_next;
  logic [7:0]  shift_next;
  logic [4:0]  cc_next;
  logic [2:0]  lvl_next;
  logic [7:0]  byte_out;
  logic        emit;
  logic        emit_ok;

  assign cfg_ready = 1'b1;

  assign cell_len = bit_time[15:1];
  assign thr      = {1'b0, cell_len} + {2'b00, cell_len[14:1]};

  assign stat.gap_over = interval > max_gap;
  assign stat.d_gt_thr = interval > {16'd0, thr};
  assign stat.cnt_full = zero_cnt == CNT_W'(MAX_CELLS);
  assign stat.cnt_zero = zero_cnt == '0;
  assign stat.out_busy = out_valid && out_stall;

  assign emit_ok = emit && (byte_cnt < BC_W'(MaxResults - 1));

  // one cell through the raw window, data shifter and sync tracking
  always_comb begin
    raw_next   = {raw_window[14:0], cmd.shift_bit};
    shift_next = cell_count[0] ? {data_shift[6:0], cmd.shift_bit} : data_shift;
    cc_next    = cell_count + 5'd1;
    if (cc_next > CC_WRAP) cc_next = CC_BACK;
    lvl_next   = sync_level;
    emit       = 1'b0;
    byte_out   = shift_next;
    if (sync_level != LVL_UNSYNC && cc_next == WORD_CELLS) begin
      if (lvl_next < LVL_SYNC3 && raw_next == SYNC_MARK) lvl_next = lvl_next + 3'd1;
      if (lvl_next >= LVL_SYNC3) begin
        cc_next  = '0;
        lvl_next = LVL_DATA;
        emit     = 1'b1;
      end
    end
    if (raw_next == SYNC_MARK) begin
      cc_next    = '0;
      raw_next   = '0;
      shift_next = '0;
      if (lvl_next == LVL_UNSYNC) lvl_next = LVL_SYNC1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time   <= BIT_TIME_RST;
      max_gap    <= MAX_GAP_RST;
      last_time  <= '0;
      raw_window <= '0;
      data_shift <= '0;
      cell_count <= '0;
      sync_level <= LVL_UNSYNC;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BIT_TIME: bit_time <= cfg_data[15:0];
          REG_MAX_GAP:  max_gap  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) last_time <= capture_time;
      if (cmd.drop) sync_level <= LVL_UNSYNC;
      if (cmd.shift) begin
        raw_window <= raw_next;
        data_shift <= shift_next;
        cell_count <= cc_next;
        sync_level <= lvl_next;
      end
      if ((cmd.shift && emit_ok) || cmd.put_status) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      interval <= capture_time - last_time;
      zero_cnt <= '0;
      flag     <= 1'b0;
      byte_cnt <= '0;
    end
    if (cmd.count_step) begin
      interval <= interval - {17'd0, cell_len};
      zero_cnt <= zero_cnt + CNT_W'(1);
    end
    if (cmd.set_flag) flag <= 1'b1;
    if (cmd.shift) begin
      if (!stat.cnt_zero) zero_cnt <= zero_cnt - CNT_W'(1);
      if (emit_ok) begin
        byte_cnt    <= byte_cnt + BC_W'(1);
        data_byte   <= byte_out;
        byte_valid  <= 1'b1;
        sync_state  <= LVL_DATA;
        gap_clamped <= flag;
        last        <= 1'b0;
      end
    end
    if (cmd.put_status) begin
      data_byte   <= '0;
      byte_valid  <= 1'b0;
      sync_state  <= sync_level;
      gap_clamped <= flag;
      last        <= 1'b1;
    end
  end

endmodule
`default_nettype wire
